// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// shared request, status, cell operation and sequencer types for the deque
// ----------------------------------------------------------------------------
package bdq_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_POP_BACK   = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_SEARCH     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_SEARCH
  } cell_op_t;

  typedef struct packed {
    logic     en;
    cell_op_t op;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_COLLECT
  } seq_state_t;

endpackage

// ===== rtl/core/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded double-ended queue built as a chain of cells, with a parallel
// equality search over the live entries
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata, lowest bit first)
//  in_     | in  | req_type[1:0], data_word[DATA_WIDTH-1:0], zero pad
//  out_    | out | data_out, found, status[1:0], entry_count, zero pad
//
//  the accept cycle in S_IDLE updates the cells and registers each cell's
//  hit and read data; S_COLLECT then ors them together into the output
//  register
//  a stalled result holds the collect cycle; the next request is taken while
//  an earlier result still waits on out_tready
//  reset clears the sequencer state, the entry count and out_tvalid; stored
//  words are not reset and are only read where live
// ----------------------------------------------------------------------------
module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // req_type[1:0], data_word, zero pad
  input  logic [((2+DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // data_out, found, status[1:0], entry_count, zero pad
  output logic [((DATA_WIDTH+3+$clog2(DEPTH+1)+7)/8)*8-1:0] out_tdata
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OUT_W  = DATA_WIDTH + 3 + CNT_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  seq_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  status_t               status_r, status_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TW-1:0]     out_tdata_r, out_tdata_nxt;

  req_t                  req;
  logic [DATA_WIDTH-1:0] word;
  logic                  accept;
  logic                  load_out;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
  logic [DEPTH-1:0]      cell_hit;
  logic [DATA_WIDTH-1:0] rd_any;
  logic                  hit_any;

  assign req    = req_t'(in_tdata[1:0]);
  assign word   = in_tdata[DATA_WIDTH+1:2];
  assign accept = in_tvalid && in_tready;

  // request decode: a rejected request leaves the stored words alone
  always_comb begin
    ctl.en     = accept;
    ctl.op     = OP_NONE;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = ST_OK;
      unique case (req)
        REQ_PUSH_BACK: begin
          if (word == '0) begin
            status_nxt = ST_ZERO;
          end else if (count_r == CNT_W'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.op    = OP_PUSH;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_POP_BACK: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.op    = OP_POP_BACK;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.op    = OP_POP_FRONT;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        REQ_SEARCH: begin
          if (word == '0) begin
            status_nxt = ST_ZERO;
          end else begin
            ctl.op = OP_SEARCH;
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] right;
    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_link
      assign right = cell_data[i+1];
    end
    bdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_idx   (CNT_W'(i)),
      .word       (word),
      .count      (count_r),
      .right_data (right),
      .data_o     (cell_data[i]),
      .hit_o      (cell_hit[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // at most one cell drives nonzero read data
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
    hit_any = |cell_hit;
  end

  assign load_out = (state_r == S_COLLECT) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_COLLECT;
        end
      end
      S_COLLECT: begin
        if (load_out) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TW'({count_r, status_r, hit_any, rd_any});
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/core/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell
// one storage slot of the deque chain: holds a word, shifts toward the front
// on a front pop, and reports its own search hit and read data
// ----------------------------------------------------------------------------
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [CNT_W-1:0]      cell_idx,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hit_r, hit_nxt;
  logic [DATA_WIDTH-1:0] rd_r, rd_nxt;
  logic                  live;
  logic                  is_back;
  logic                  is_front;

  assign live     = cell_idx < count;
  assign is_back  = (cell_idx + CNT_W'(1)) == count;
  assign is_front = cell_idx == '0;

  always_comb begin
    data_nxt = data_r;
    hit_nxt  = hit_r;
    rd_nxt   = rd_r;
    if (ctl.en) begin
      hit_nxt = 1'b0;
      rd_nxt  = '0;
      unique case (ctl.op)
        OP_PUSH: begin
          if (cell_idx == count) begin
            data_nxt = word;
          end
        end
        OP_POP_BACK: begin
          if (is_back) begin
            rd_nxt = data_r;
          end
        end
        OP_POP_FRONT: begin
          // every cell takes its neighbor's word, the front one is read out
          data_nxt = right_data;
          if (is_front) begin
            rd_nxt = data_r;
          end
        end
        OP_SEARCH: begin
          hit_nxt = live && (data_r == word);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
    rd_r   <= rd_nxt;
  end

  assign data_o = data_r;
  assign hit_o  = hit_r;
  assign rd_o   = rd_r;

endmodule
